FILE: rtl/iin_pkg.sv
// ----------------------------------------------------------------------------
// iin_pkg
// Shared types and constants for the interval interpolate/normalize block.
// ----------------------------------------------------------------------------
package iin_pkg;

  localparam int QUERY_DEPTH = 64;
  localparam int LANES       = 8;

  localparam int QW      = (QUERY_DEPTH > 1) ? $clog2(QUERY_DEPTH) : 1;
  localparam int CNT_W   = $clog2(QUERY_DEPTH + 1);
  localparam int LANE_W  = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int STORE_DEPTH = QUERY_DEPTH * LANES;
  localparam int SAW     = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  localparam int POS_W   = 32;
  localparam int PROB_W  = 14;
  localparam int SHARE_W = 10;
  localparam int SLOT_W  = 6;
  localparam int CMD_W   = 2;
  localparam int POP_W   = 4;
  localparam int HALF_W  = 17;
  localparam int FRAC_W  = 16;
  localparam int PROD_W  = PROB_W + POS_W;
  localparam int NUM_W   = PROD_W + 1;
  localparam int SUM_W   = NUM_W + LANE_W;
  localparam int DIVN_W  = NUM_W + FRAC_W + 1;
  localparam int DIVD_W  = SUM_W + 1;
  localparam int DCNT_W  = $clog2(HALF_W);

  localparam int IN_DATA_W  = 144;
  localparam int OUT_DATA_W = 88;

  localparam logic [SHARE_W-1:0] SHARE_MAX = SHARE_W'(1000);

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD  = 2'd0,
    CMD_HAP   = 2'd1,
    CMD_BREAK = 2'd2
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_FETCH,
    ST_CHECK,
    ST_EMIT,
    ST_MUL_P,
    ST_MUL_C,
    ST_MUL_ADD,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_Q_END,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic accept;
    logic decode;
    logic fetch;
    logic check;
    logic emit;
    logic mul_p;
    logic mul_c;
    logic mul_add;
    logic div_start;
    logic div_fin;
    logic q_end;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             hit;
    logic             pend_valid;
    logic             div_done;
    logic             lane_last;
    logic             out_free;
  } dp_stat_t;

endpackage

FILE: rtl/iin_ram.sv
// ----------------------------------------------------------------------------
// iin_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module iin_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                     clk,
  input  logic                                     wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                         wr_data,
  input  logic                                     rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/iin_div.sv
// ----------------------------------------------------------------------------
// iin_div
// Restoring divider, one quotient bit per cycle, quotient known below 2^17.
// ----------------------------------------------------------------------------
module iin_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [iin_pkg::DIVN_W-1:0]   numer,
  input  logic [iin_pkg::DIVD_W-1:0]   denom,
  output logic                         done,
  output logic [iin_pkg::HALF_W-1:0]   quot
);

  localparam int DSH_W = iin_pkg::DIVD_W + iin_pkg::HALF_W - 1;

  logic                        busy;
  logic [iin_pkg::DCNT_W-1:0]  cnt;
  logic [iin_pkg::DIVN_W-1:0]  rem;
  logic [DSH_W-1:0]            dsh;
  logic [DSH_W-1:0]            rem_ext;
  logic                        ge;

  assign rem_ext = DSH_W'(rem);
  assign ge      = (rem_ext >= dsh);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= iin_pkg::DCNT_W'(iin_pkg::HALF_W - 1);
        rem  <= numer;
        dsh  <= {denom, {(iin_pkg::HALF_W-1){1'b0}}};
        quot <= '0;
      end else if (busy) begin
        // subtract the shifted divisor where it fits
        if (ge) begin
          rem <= iin_pkg::DIVN_W'(rem_ext - dsh);
        end
        quot <= {quot[iin_pkg::HALF_W-2:0], ge};
        dsh  <= dsh >> 1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

endmodule

FILE: rtl/iin_ctrl.sv
// ----------------------------------------------------------------------------
// iin_ctrl
// Sequencer: decodes items, walks covered queries, steps lanes and divides.
// ----------------------------------------------------------------------------
module iin_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  iin_pkg::dp_stat_t   stat,
  output iin_pkg::ctrl_cmd_t  cmd
);

  iin_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= iin_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      iin_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.accept = 1'b1;
          state_next = iin_pkg::ST_DECODE;
        end
      end
      iin_pkg::ST_DECODE: begin
        cmd.decode = 1'b1;
        if (stat.cmd == iin_pkg::CMD_BREAK) begin
          state_next = iin_pkg::ST_FETCH;
        end else begin
          state_next = iin_pkg::ST_IDLE;
        end
      end
      iin_pkg::ST_FETCH: begin
        cmd.fetch  = 1'b1;
        state_next = iin_pkg::ST_CHECK;
      end
      iin_pkg::ST_CHECK: begin
        cmd.check = 1'b1;
        if (stat.pend_valid) begin
          state_next = iin_pkg::ST_EMIT;
        end else if (stat.hit) begin
          state_next = iin_pkg::ST_MUL_P;
        end else begin
          state_next = iin_pkg::ST_FINISH;
        end
      end
      iin_pkg::ST_EMIT: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = stat.hit ? iin_pkg::ST_MUL_P : iin_pkg::ST_FINISH;
        end
      end
      iin_pkg::ST_MUL_P: begin
        cmd.mul_p  = 1'b1;
        state_next = iin_pkg::ST_MUL_C;
      end
      iin_pkg::ST_MUL_C: begin
        cmd.mul_c  = 1'b1;
        state_next = iin_pkg::ST_MUL_ADD;
      end
      iin_pkg::ST_MUL_ADD: begin
        cmd.mul_add = 1'b1;
        state_next  = stat.lane_last ? iin_pkg::ST_DIV_START : iin_pkg::ST_MUL_P;
      end
      iin_pkg::ST_DIV_START: begin
        cmd.div_start = 1'b1;
        state_next    = iin_pkg::ST_DIV_WAIT;
      end
      iin_pkg::ST_DIV_WAIT: begin
        if (stat.div_done) begin
          cmd.div_fin = 1'b1;
          state_next  = stat.lane_last ? iin_pkg::ST_Q_END : iin_pkg::ST_DIV_START;
        end
      end
      iin_pkg::ST_Q_END: begin
        cmd.q_end  = 1'b1;
        state_next = iin_pkg::ST_FETCH;
      end
      iin_pkg::ST_FINISH: begin
        cmd.finish = 1'b1;
        state_next = iin_pkg::ST_IDLE;
      end
      default: begin
        state_next = iin_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/iin_datapath.sv
// ----------------------------------------------------------------------------
// iin_datapath
// Item registers, query and half stores, lane multiplier, divider, output.
// ----------------------------------------------------------------------------
module iin_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  iin_pkg::ctrl_cmd_t                cmd,
  output iin_pkg::dp_stat_t                 stat,
  input  logic [iin_pkg::IN_DATA_W-1:0]     s_tdata,
  input  logic [iin_pkg::CMD_W-1:0]         s_tuser,
  input  logic                              cfg_wr,
  input  logic [iin_pkg::POP_W-1:0]         cfg_data,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [iin_pkg::OUT_DATA_W-1:0]    m_tdata,
  output logic                              m_tlast
);

  localparam int LANES = iin_pkg::LANES;

  logic [iin_pkg::POP_W-1:0]   pop_count;
  logic [iin_pkg::POP_W-1:0]   lanes_used;
  logic [iin_pkg::CMD_W-1:0]   cmd_r;
  logic [iin_pkg::POS_W-1:0]   pos;
  logic [iin_pkg::PROB_W-1:0]  cur  [LANES];
  logic [iin_pkg::PROB_W-1:0]  prev [LANES];
  logic [iin_pkg::CNT_W-1:0]   query_count;
  logic [iin_pkg::CNT_W-1:0]   query_pointer;
  logic [iin_pkg::POS_W-1:0]   segment_start;
  logic                        parity;
  logic [iin_pkg::POS_W-1:0]   q_rd;
  logic                        hit;
  logic                        hit_r;
  logic                        range0;
  logic [iin_pkg::POS_W-1:0]   rd_len;
  logic [iin_pkg::POS_W-1:0]   q_dist;
  logic [iin_pkg::LANE_W-1:0]  lane;
  logic                        lane_last;
  logic [iin_pkg::PROD_W-1:0]  prod;
  logic [iin_pkg::PROD_W-1:0]  tmp;
  logic [iin_pkg::PROB_W-1:0]  mul_a;
  logic [iin_pkg::POS_W-1:0]   mul_b;
  logic [iin_pkg::NUM_W-1:0]   nsum;
  logic [iin_pkg::NUM_W-1:0]   num [LANES];
  logic [iin_pkg::SUM_W-1:0]   sum;
  logic [iin_pkg::DIVN_W-1:0]  div_numer;
  logic [iin_pkg::DIVD_W-1:0]  div_denom;
  logic                        div_done;
  logic [iin_pkg::HALF_W-1:0]  quot;
  logic [iin_pkg::HALF_W-1:0]  half;
  logic [iin_pkg::HALF_W-1:0]  h1;
  logic [iin_pkg::SAW-1:0]     store_addr;
  logic [iin_pkg::HALF_W:0]    pair;
  logic [27:0]                 pair_scaled;
  logic [11:0]                 share_raw;
  logic [iin_pkg::SHARE_W-1:0] share;
  logic                        pend_valid;
  logic [iin_pkg::SLOT_W-1:0]  pend_slot;
  logic [iin_pkg::SHARE_W-1:0] pend_share [LANES];
  logic [iin_pkg::SLOT_W-1:0]  out_slot;
  logic [iin_pkg::SHARE_W-1:0] out_share [8];
  logic                        out_free;

  // lanes in use: zero acts as one, clamp to the lane count
  always_comb begin
    if (pop_count == '0) begin
      lanes_used = iin_pkg::POP_W'(1);
    end else if (pop_count > iin_pkg::POP_W'(LANES)) begin
      lanes_used = iin_pkg::POP_W'(LANES);
    end else begin
      lanes_used = pop_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pop_count <= iin_pkg::POP_W'(8);
    end else if (cfg_wr) begin
      pop_count <= cfg_data;
    end
  end

  iin_ram #(.WIDTH(iin_pkg::POS_W), .DEPTH(iin_pkg::QUERY_DEPTH)) u_qram (
    .clk     (clk),
    .wr_en   (cmd.decode && (cmd_r == iin_pkg::CMD_LOAD) &&
              (query_count < iin_pkg::CNT_W'(iin_pkg::QUERY_DEPTH))),
    .wr_addr (query_count[iin_pkg::QW-1:0]),
    .wr_data (pos),
    .rd_en   (cmd.fetch),
    .rd_addr (query_pointer[iin_pkg::QW-1:0]),
    .rd_data (q_rd)
  );

  assign store_addr = iin_pkg::SAW'(query_pointer[iin_pkg::QW-1:0]) *
                      iin_pkg::SAW'(LANES) + iin_pkg::SAW'(lane);

  iin_ram #(.WIDTH(iin_pkg::HALF_W), .DEPTH(iin_pkg::STORE_DEPTH)) u_hram (
    .clk     (clk),
    .wr_en   (cmd.div_fin && !parity),
    .wr_addr (store_addr),
    .wr_data (half),
    .rd_en   (cmd.div_start),
    .rd_addr (store_addr),
    .rd_data (h1)
  );

  assign hit = (query_pointer < query_count) && (q_rd >= segment_start) && (q_rd <= pos);
  assign lane_last = (lane == iin_pkg::LANE_W'(LANES - 1));

  // one multiplier, shared by both terms of every lane
  always_comb begin
    if (cmd.mul_p) begin
      mul_a = prev[lane];
      mul_b = range0 ? iin_pkg::POS_W'(1) : rd_len;
    end else begin
      mul_a = cur[lane];
      mul_b = range0 ? '0 : q_dist;
    end
  end

  assign nsum      = iin_pkg::NUM_W'(tmp) + iin_pkg::NUM_W'(prod);
  assign div_numer = (iin_pkg::DIVN_W'(num[lane]) << iin_pkg::FRAC_W) +
                     iin_pkg::DIVN_W'(sum);
  assign div_denom = {sum, 1'b0};
  assign half      = (sum == '0) ? '0 : quot;

  iin_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .numer (div_numer),
    .denom (div_denom),
    .done  (div_done),
    .quot  (quot)
  );

  // pair sum to thousandths, round half up, saturate
  assign pair        = {1'b0, h1} + {1'b0, half};
  assign pair_scaled = 28'(pair) * 28'd1000 + 28'd32768;
  assign share_raw   = pair_scaled[27:16];
  assign share       = (share_raw > 12'(iin_pkg::SHARE_MAX)) ? iin_pkg::SHARE_MAX :
                       iin_pkg::SHARE_W'(share_raw);

  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      query_count   <= '0;
      query_pointer <= '0;
      segment_start <= iin_pkg::POS_W'(1);
      parity        <= 1'b1;
      pend_valid    <= 1'b0;
      m_tvalid      <= 1'b0;
      for (int k = 0; k < LANES; k++) begin
        prev[k] <= '0;
      end
    end else begin
      if (cmd.accept) begin
        cmd_r <= s_tuser;
        pos   <= s_tdata[iin_pkg::POS_W-1:0];
        for (int k = 0; k < LANES; k++) begin
          cur[k] <= (iin_pkg::POP_W'(k) < lanes_used) ?
                    s_tdata[iin_pkg::POS_W + k*iin_pkg::PROB_W +: iin_pkg::PROB_W] : '0;
        end
      end
      if (cmd.decode) begin
        case (cmd_r)
          iin_pkg::CMD_LOAD: begin
            if (query_count < iin_pkg::CNT_W'(iin_pkg::QUERY_DEPTH)) begin
              query_count <= query_count + 1'b1;
            end
          end
          iin_pkg::CMD_HAP: begin
            parity        <= ~parity;
            query_pointer <= '0;
            segment_start <= iin_pkg::POS_W'(1);
          end
          iin_pkg::CMD_BREAK: begin
            if (pos == iin_pkg::POS_W'(1)) begin
              for (int k = 0; k < LANES; k++) begin
                prev[k] <= cur[k];
              end
            end
          end
          default: begin
          end
        endcase
      end
      if (cmd.check) begin
        hit_r  <= hit;
        range0 <= (pos == segment_start);
        rd_len <= pos - q_rd;
        q_dist <= q_rd - segment_start;
        lane   <= '0;
        sum    <= '0;
      end
      if (cmd.mul_p) begin
        prod <= iin_pkg::PROD_W'(mul_a) * iin_pkg::PROD_W'(mul_b);
      end
      if (cmd.mul_c) begin
        prod <= iin_pkg::PROD_W'(mul_a) * iin_pkg::PROD_W'(mul_b);
        tmp  <= prod;
      end
      if (cmd.mul_add) begin
        num[lane] <= nsum;
        sum       <= sum + iin_pkg::SUM_W'(nsum);
        lane      <= lane_last ? '0 : lane + 1'b1;
      end
      if (cmd.div_fin) begin
        if (parity) begin
          pend_share[lane] <= share;
        end
        lane <= lane_last ? '0 : lane + 1'b1;
      end
      if (cmd.q_end) begin
        pend_slot     <= iin_pkg::SLOT_W'(query_pointer[iin_pkg::QW-1:0]);
        pend_valid    <= parity;
        query_pointer <= query_pointer + 1'b1;
      end
      if (cmd.emit) begin
        pend_valid <= 1'b0;
        m_tvalid   <= 1'b1;
        out_slot   <= pend_slot;
        m_tlast    <= !hit_r;
        for (int k = 0; k < 8; k++) begin
          out_share[k] <= (k < LANES) ? pend_share[(k < LANES) ? k : 0] : '0;
        end
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (cmd.finish) begin
        segment_start <= pos;
        for (int k = 0; k < LANES; k++) begin
          prev[k] <= cur[k];
        end
      end
    end
  end

  assign m_tdata = {2'b00, out_share[7], out_share[6], out_share[5], out_share[4],
                    out_share[3], out_share[2], out_share[1], out_share[0], out_slot};

  assign stat.cmd        = cmd_r;
  assign stat.hit        = cmd.check ? hit : hit_r;
  assign stat.pend_valid = pend_valid;
  assign stat.div_done   = div_done;
  assign stat.lane_last  = lane_last;
  assign stat.out_free   = out_free;

endmodule

FILE: rtl/interval_interpolate_normalize.sv
// ----------------------------------------------------------------------------
// interval_interpolate_normalize
// Piecewise linear interpolation of lane vectors at loaded query positions,
// normalized to half sums and added over haplotype pairs.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake             payload
//  s_*      in   s_tvalid / s_tready   s_tuser = cmd, s_tdata = position, prob0..7
//  m_*      out  m_tvalid / m_tready   m_tdata = query_slot, share0..7, m_tlast
//  cfg_*    in   cfg_valid / cfg_ready cfg_data = pop_count
//
//  Load and haplotype-start items pass through decode and return to idle.
//  A breakpoint walks each covered query: the shared 14x32 multiplier over
//  eight lanes, the shared 17-step divider with one division per lane, and
//  an advance and refetch of the next query.
//  The odd pass hands each result to the output in an emit state.
//  Reset is synchronous; it clears counters, segment start and the
//  previous vector and sets parity. Query and half stores are not cleared.
//  A stalled m_tready holds the walk only when a new result is ready to go.
//  cfg_ready is always high; write pop_count only while idle.
//
module interval_interpolate_normalize (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // s_tdata: position[31:0], prob0 .. prob7 (14 bits each) from bit 32 up
  input  logic [iin_pkg::IN_DATA_W-1:0]  s_tdata,
  // s_tuser: cmd[1:0]
  input  logic [iin_pkg::CMD_W-1:0]      s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // m_tdata: query_slot[5:0], share0 .. share7 (10 bits each), 2 zero bits
  output logic [iin_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic                           m_tlast,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [iin_pkg::POP_W-1:0]      cfg_data
);

  iin_pkg::ctrl_cmd_t cmd;
  iin_pkg::dp_stat_t  stat;

  // configuration is accepted every cycle
  assign cfg_ready = 1'b1;

  // sequencer: owns the state and issues one command group per cycle
  iin_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath: stores, arithmetic and the output register
  iin_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .cfg_wr   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

FILE: rtl/iin_checker.sv
// ----------------------------------------------------------------------------
// iin_checker
// Port-level checks for interval_interpolate_normalize.
// ----------------------------------------------------------------------------
module iin_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic [iin_pkg::CMD_W-1:0]      s_tuser,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [iin_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic                           m_tlast
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled result changed");

  // shares never exceed one thousand
  a_share_max: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[15:6] <= 10'd1000) && (m_tdata[25:16] <= 10'd1000) &&
                 (m_tdata[35:26] <= 10'd1000) && (m_tdata[45:36] <= 10'd1000) &&
                 (m_tdata[55:46] <= 10'd1000) && (m_tdata[65:56] <= 10'd1000) &&
                 (m_tdata[75:66] <= 10'd1000) && (m_tdata[85:76] <= 10'd1000))
    else $error("share out of range");

  // drop ready after taking a breakpoint
  a_break_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == iin_pkg::CMD_BREAK) |=> !s_tready)
    else $error("ready held during breakpoint");

  // a load taken while no result is out raises no result
  a_load_quiet: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == iin_pkg::CMD_LOAD) && !m_tvalid |=> !m_tvalid)
    else $error("result after load");

  // reset empties the output
  a_reset_out: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

bind interval_interpolate_normalize iin_checker u_iin_checker (.*);
